[rtl/core/vrle_pkg.sv]
// shared constants for the voxel run-length varint encoder
// used by the front end, record queue, back end and top level
package vrle_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int BYTE_BITS      = 8;
	localparam int GROUP_BITS     = 7;
	localparam int FIFO_DEPTH     = 2;

	localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'b1111111;
	localparam logic [BYTE_BITS-1:0]  STOP_BIT   = 8'b10000000;

	localparam logic CMD_VOXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// record layout, lowest bits first: id, data, start x, start y, start z, length
	function automatic int rec_width(input int coord_bits);
		return 2 * BYTE_BITS + 4 * coord_bits + 1;
	endfunction

	// input tdata: x, y, z, id, data padded to whole bytes
	function automatic int in_width(input int coord_bits);
		return ((3 * coord_bits + 2 * BYTE_BITS + 7) / 8) * 8;
	endfunction

endpackage

[rtl/core/voxel_run_length_varint_encoder.sv]
// voxel run-length encoder with 7-bit varint record output, top level
// depends on vrle_pkg, vrle_front, vrle_fifo and vrle_back
//
// Usage:
//   s_* channel takes one voxel or a flush command per transfer: tuser is the
//   command (0 voxel, 1 flush), tdata packs x, y, z, block id and block data.
//   m_* channel gives one record byte per transfer, tlast on the final byte.
//   A voxel that extends the pending run along x produces nothing. A voxel that
//   breaks the run, or a flush, queues the pending run as a record.
//   The front end takes one item per cycle while the two-entry record queue has
//   room; a breaking item is taken even with a full output as long as the queue
//   is not full.
//   The back end sends one byte per cycle while m_tready is high: 6 to 14 bytes
//   for a 16-bit coordinate record, plus an idle gap between records while the
//   next record is fetched from the queue. A finished run is written to the queue,
//   popped into the serializer, and its first byte is then registered onto m_tdata.
//   Reset clears the pending run and the queue; no record is pending after it.
//   When the receiver stalls, the output byte holds, the serializer waits, and
//   once the queue fills s_tready drops until a record drains.
module voxel_run_length_varint_encoder #(
	parameter int COORD_BITS = vrle_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// x, y, z (COORD_BITS each), block_id (8), block_data (8), zero padding
	input  logic [vrle_pkg::in_width(COORD_BITS)-1:0] s_tdata,
	// command
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_byte (8)
	output logic [7:0]            m_tdata,
	// record_last
	output logic                  m_tlast
);

	localparam int REC_W   = vrle_pkg::rec_width(COORD_BITS);
	localparam int CB      = COORD_BITS;

	logic             push;
	logic [REC_W-1:0] push_rec;
	logic             pop;
	logic [REC_W-1:0] pop_rec;
	logic             q_empty;
	logic             q_full;

	vrle_front #(
		.COORD_BITS (COORD_BITS),
		.REC_W      (REC_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.command    (s_tuser),
		.coord_x    (s_tdata[CB-1:0]),
		.coord_y    (s_tdata[2*CB-1:CB]),
		.coord_z    (s_tdata[3*CB-1:2*CB]),
		.block_id   (s_tdata[3*CB+7:3*CB]),
		.block_data (s_tdata[3*CB+15:3*CB+8]),
		.push       (push),
		.push_rec   (push_rec),
		.queue_full (q_full)
	);

	vrle_fifo #(
		.WIDTH (REC_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_rec),
		.pop       (pop),
		.pop_data  (pop_rec),
		.empty     (q_empty),
		.full      (q_full)
	);

	vrle_back #(
		.COORD_BITS (COORD_BITS),
		.REC_W      (REC_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_avail   (!q_empty),
		.rec         (pop_rec),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.record_last (m_tlast)
	);

endmodule

[rtl/core/vrle_front.sv]
// front end: holds the pending run, merges voxels into it and queues finished runs
// depends on vrle_pkg
module vrle_front #(
	parameter int COORD_BITS = vrle_pkg::COORD_BITS_DEF,
	parameter int REC_W      = vrle_pkg::rec_width(COORD_BITS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	input  logic [COORD_BITS-1:0] coord_z,
	input  logic [7:0]            block_id,
	input  logic [7:0]            block_data,
	output logic                  push,
	output logic [REC_W-1:0]      push_rec,
	input  logic                  queue_full
);

	logic [7:0]            cur_id_q;
	logic [7:0]            cur_variant_q;
	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [COORD_BITS-1:0] start_z_q;
	logic [COORD_BITS:0]   run_count_q;

	logic                  accept;
	logic                  pending;
	logic                  extend;
	logic [COORD_BITS+1:0] next_x;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign pending  = (run_count_q != '0);
	assign next_x   = {2'b00, start_x_q} + {1'b0, run_count_q};
	assign extend   = pending && (block_id == cur_id_q) && (block_data == cur_variant_q)
		&& (coord_y == start_y_q) && (coord_z == start_z_q)
		&& ({2'b00, coord_x} == next_x);

	assign push     = accept && pending && ((command == vrle_pkg::CMD_FLUSH) || !extend);
	assign push_rec = {run_count_q, start_z_q, start_y_q, start_x_q, cur_variant_q, cur_id_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_id_q      <= '0;
			cur_variant_q <= '0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_z_q     <= '0;
			run_count_q   <= '0;
		end else if (accept) begin
			if (command == vrle_pkg::CMD_FLUSH) begin
				cur_id_q      <= '0;
				cur_variant_q <= '0;
				start_x_q     <= '0;
				start_y_q     <= '0;
				start_z_q     <= '0;
				run_count_q   <= '0;
			end else if (extend) begin
				run_count_q <= run_count_q + 1'b1;
			end else begin
				cur_id_q      <= block_id;
				cur_variant_q <= block_data;
				start_x_q     <= coord_x;
				start_y_q     <= coord_y;
				start_z_q     <= coord_z;
				run_count_q   <= {{COORD_BITS{1'b0}}, 1'b1};
			end
		end
	end

endmodule

[rtl/core/vrle_fifo.sv]
// short record queue between the front end and the byte serializer
// depends on vrle_pkg for its depth
module vrle_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic             full
);

	localparam int DEPTH = vrle_pkg::FIFO_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/vrle_back.sv]
// back end: serializes one queued run record into id, data and four varint fields
// depends on vrle_pkg
module vrle_back #(
	parameter int COORD_BITS = vrle_pkg::COORD_BITS_DEF,
	parameter int REC_W      = vrle_pkg::rec_width(COORD_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_avail,
	input  logic [REC_W-1:0] rec,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             record_last
);

	localparam int BB   = vrle_pkg::BYTE_BITS;
	localparam int GB   = vrle_pkg::GROUP_BITS;
	localparam int LENW = COORD_BITS + 1;
	localparam int VALW = (LENW > GB) ? LENW : GB;

	typedef enum logic [2:0] {
		FLD_ID,
		FLD_DATA,
		FLD_X,
		FLD_Y,
		FLD_Z,
		FLD_LEN
	} fld_t;

	logic                  busy_q;
	fld_t                  fld_q;
	logic [VALW-1:0]       val_q;
	logic [BB-1:0]         id_q;
	logic [BB-1:0]         data_q;
	logic [COORD_BITS-1:0] sx_q;
	logic [COORD_BITS-1:0] sy_q;
	logic [COORD_BITS-1:0] sz_q;
	logic [LENW-1:0]       len_q;

	logic                  step;
	logic                  fld_done;
	logic [BB-1:0]         nxt_byte;
	logic [VALW-1:0]       val_shift;
	logic [GB-1:0]         low;

	assign pop       = !busy_q && rec_avail;
	assign step      = busy_q && (!out_valid || out_ready);
	assign val_shift = val_q >> GB;
	assign low       = val_q[GB-1:0] & vrle_pkg::GROUP_MASK;

	always_comb begin
		nxt_byte = '0;
		fld_done = 1'b1;
		case (fld_q)
			FLD_ID: begin
				nxt_byte = id_q;
			end
			FLD_DATA: begin
				nxt_byte = data_q;
			end
			default: begin
				if (val_shift == '0) begin
					nxt_byte = {1'b0, low} | vrle_pkg::STOP_BIT;
				end else begin
					nxt_byte = {1'b0, low};
					fld_done = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			id_q   <= rec[BB-1:0];
			data_q <= rec[2*BB-1:BB];
			sx_q   <= rec[2*BB+COORD_BITS-1:2*BB];
			sy_q   <= rec[2*BB+2*COORD_BITS-1:2*BB+COORD_BITS];
			sz_q   <= rec[2*BB+3*COORD_BITS-1:2*BB+2*COORD_BITS];
			len_q  <= rec[REC_W-1:2*BB+3*COORD_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fld_q       <= FLD_ID;
			val_q       <= '0;
			out_valid   <= 1'b0;
			out_byte    <= '0;
			record_last <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				fld_q  <= FLD_ID;
			end
			if (step) begin
				out_valid   <= 1'b1;
				out_byte    <= nxt_byte;
				record_last <= (fld_q == FLD_LEN) && fld_done;
				if (!fld_done) begin
					val_q <= val_shift;
				end else begin
					case (fld_q)
						FLD_ID: begin
							fld_q <= FLD_DATA;
						end
						FLD_DATA: begin
							fld_q <= FLD_X;
							val_q <= VALW'(sx_q);
						end
						FLD_X: begin
							fld_q <= FLD_Y;
							val_q <= VALW'(sy_q);
						end
						FLD_Y: begin
							fld_q <= FLD_Z;
							val_q <= VALW'(sz_q);
						end
						FLD_Z: begin
							fld_q <= FLD_LEN;
							val_q <= VALW'(len_q);
						end
						default: begin
							fld_q  <= FLD_ID;
							busy_q <= 1'b0;
						end
					endcase
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

[test/testbench.sv]
// self-checking testbench for the voxel run-length varint encoder
// predicts every record byte from the accepted voxel stream and compares
// depends on vrle_pkg and voxel_run_length_varint_encoder
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} rec_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// pending run as the encoder should hold it
	logic [7:0]  run_id;
	logic [7:0]  run_data;
	logic [15:0] run_x;
	logic [15:0] run_y;
	logic [15:0] run_z;
	logic [16:0] run_len;

	rec_byte_t record_bytes[$];
	int        errors = 0;
	int        send_idle = 0;
	int        recv_idle = 0;
	int        hold_left = 0;

	voxel_run_length_varint_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic push_byte(input logic [7:0] value, input logic last);
		rec_byte_t b;
		b.value = value;
		b.last  = last;
		record_bytes.insert(record_bytes.size(), b);
	endtask

	task automatic push_varint(input logic [16:0] v, input logic fin);
		logic [6:0] low;
		bit         done;
		done = 1'b0;
		while (!done) begin
			low = v[6:0] & vrle_pkg::GROUP_MASK;
			if ({10'b0, low} == v) begin
				push_byte({1'b0, low} | vrle_pkg::STOP_BIT, fin);
				done = 1'b1;
			end else begin
				push_byte({1'b0, low}, 1'b0);
				v = v >> vrle_pkg::GROUP_BITS;
			end
		end
	endtask

	task automatic queue_run_record();
		push_byte(run_id, 1'b0);
		push_byte(run_data, 1'b0);
		push_varint({1'b0, run_x}, 1'b0);
		push_varint({1'b0, run_y}, 1'b0);
		push_varint({1'b0, run_z}, 1'b0);
		push_varint(run_len, 1'b1);
	endtask

	task automatic clear_run();
		run_id   = '0;
		run_data = '0;
		run_x    = '0;
		run_y    = '0;
		run_z    = '0;
		run_len  = '0;
	endtask

	// track the pending run and queue the record bytes an item releases
	task automatic predict_runs(input logic cmd, input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [7:0] id, input logic [7:0] dv);
		if (cmd == vrle_pkg::CMD_FLUSH) begin
			if (run_len != 0)
				queue_run_record();
			clear_run();
		end else if (run_len != 0 && id == run_id && dv == run_data && y == run_y &&
				z == run_z && {2'b0, x} == {2'b0, run_x} + {1'b0, run_len}) begin
			run_len = run_len + 17'd1;
		end else begin
			if (run_len != 0)
				queue_run_record();
			run_id   = id;
			run_data = dv;
			run_x    = x;
			run_y    = y;
			run_z    = z;
			run_len  = 17'd1;
		end
	endtask

	task automatic send_item(input logic cmd, input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [7:0] id, input logic [7:0] dv);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {dv, id, z, y, x};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		predict_runs(cmd, x, y, z, id, dv);
	endtask

	task automatic send_flush();
		send_item(vrle_pkg::CMD_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		int n;
		s_tvalid <= 1'b0;
		n = 0;
		while (record_bytes.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (16) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(3))
			0: return 16'($urandom_range(127));
			1: return 16'($urandom_range(16383));
			2: return 16'($urandom);
			default: return $urandom_range(1) ? 16'hffff : 16'h0000;
		endcase
	endfunction

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// compare every output transfer with the oldest predicted byte
	always @(posedge clk) begin
		rec_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (record_bytes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected byte %02h last %0b", m_tdata, m_tlast);
			end else begin
				want = record_bytes.pop_front();
				if (m_tdata !== want.value || m_tlast !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("byte mismatch: expected %02h last %0b, got %02h last %0b",
							want.value, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	task automatic test_directed();
		send_flush();
		send_item(vrle_pkg::CMD_VOXEL, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
		send_item(vrle_pkg::CMD_VOXEL, 16'd1, 16'd0, 16'd0, 8'd0, 8'd0);
		send_item(vrle_pkg::CMD_VOXEL, 16'd2, 16'd0, 16'd0, 8'd1, 8'd0);
		send_item(vrle_pkg::CMD_VOXEL, 16'd3, 16'd0, 16'd0, 8'd1, 8'd1);
		send_item(vrle_pkg::CMD_VOXEL, 16'd4, 16'd1, 16'd0, 8'd1, 8'd1);
		send_item(vrle_pkg::CMD_VOXEL, 16'd5, 16'd1, 16'd1, 8'd1, 8'd1);
		send_item(vrle_pkg::CMD_VOXEL, 16'd7, 16'd1, 16'd1, 8'd1, 8'd1);
		send_item(vrle_pkg::CMD_VOXEL, 16'd6, 16'd1, 16'd1, 8'd1, 8'd1);
		send_flush();
		send_flush();
		send_item(vrle_pkg::CMD_VOXEL, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff);
		send_item(vrle_pkg::CMD_VOXEL, 16'h0000, 16'hffff, 16'hffff, 8'hff, 8'hff);
		send_item(vrle_pkg::CMD_VOXEL, 16'h0001, 16'hffff, 16'hffff, 8'hff, 8'hff);
		send_flush();
		send_item(vrle_pkg::CMD_VOXEL, 16'd127, 16'd128, 16'd16383, 8'h5a, 8'ha5);
		send_item(vrle_pkg::CMD_VOXEL, 16'd16384, 16'd16383, 16'd128, 8'ha5, 8'h5a);
		send_item(vrle_pkg::CMD_VOXEL, 16'd16385, 16'd16383, 16'd128, 8'ha5, 8'h5a);
		send_flush();
		wait_drained();
	endtask

	// mostly well-formed runs with random content, some flushes and noise
	task automatic test_random_runs(input int n_items, input int s_idle, input int r_idle,
			input bit with_long_run);
		logic [15:0] x, y, z;
		logic [7:0]  id, dv;
		int          len, sent, kind;
		send_idle = s_idle;
		recv_idle = r_idle;
		sent = 0;
		if (with_long_run) begin
			x = pick_coord();
			y = pick_coord();
			z = pick_coord();
			id = 8'($urandom);
			dv = 8'($urandom);
			for (int i = 0; i < 130; i++)
				send_item(vrle_pkg::CMD_VOXEL, x + 16'(i), y, z, id, dv);
			sent += 130;
		end
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				x = pick_coord();
				y = pick_coord();
				z = pick_coord();
				id = 8'($urandom);
				dv = 8'($urandom);
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_item(vrle_pkg::CMD_VOXEL, x + 16'(i), y, z, id, dv);
				sent += len;
			end else if (kind < 90) begin
				send_flush();
				sent++;
			end else begin
				// near miss on the pending run: one field off
				x = run_x + 16'(run_len);
				y = run_y;
				z = run_z;
				id = run_id;
				dv = run_data;
				case ($urandom_range(4))
					0: x = x + 16'd1;
					1: y = y ^ 16'(1 << $urandom_range(15));
					2: z = z ^ 16'(1 << $urandom_range(15));
					3: id = id ^ 8'(1 << $urandom_range(7));
					default: dv = dv ^ 8'(1 << $urandom_range(7));
				endcase
				send_item(vrle_pkg::CMD_VOXEL, x, y, z, id, dv);
				sent++;
			end
		end
		send_flush();
		wait_drained();
	endtask

	// receiver holds off while breaking voxels keep coming, input must stall
	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		hold_left = 400;
		for (int i = 0; i < 20; i++)
			send_item(vrle_pkg::CMD_VOXEL, 16'($urandom), 16'($urandom), 16'($urandom),
				8'(i), 8'($urandom));
		send_flush();
		wait_drained();
	endtask

	initial begin
		clear_run();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 31;
		recv_idle = 46;
		test_directed();
		test_random_runs(150, 31, 46, 1'b1);
		test_random_runs(45, 46, 31, 1'b0);
		test_random_runs(45, 0, 0, 1'b0);
		test_backpressure();
		if (errors == 0 && record_bytes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/vrle_pkg.sv
rtl/core/vrle_front.sv
rtl/core/vrle_fifo.sv
rtl/core/vrle_back.sv
rtl/core/voxel_run_length_varint_encoder.sv
test/testbench.sv
